>>> rtl/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// shared types and constants of the nearest center search block
// ----------------------------------------------------------------------------
package ncs_pkg;

	localparam int unsigned ENTRIES_DEFAULT = 16;

	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned COORD_W = 11;
	localparam int unsigned COUNT_W = 5;

	// difference of two coordinates needs one more bit, its square stays below 2^22
	localparam int unsigned DIFF_W = COORD_W + 1;
	localparam int unsigned PROD_W = 2 * DIFF_W;
	localparam int unsigned SQ_W   = 2 * COORD_W;
	localparam int unsigned DIST_W = SQ_W + 1;

	localparam int unsigned IN_FIELDS_W = SLOT_W + ID_W + 2 * COORD_W;
	localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ID_W;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// item as it travels down the row of cells, with the running best of a query
	typedef struct packed {
		cmd_t                      cmd;
		logic [SLOT_W-1:0]         slot;
		logic [ID_W-1:0]           entry_id;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic                      have;
		logic [DIST_W-1:0]         best_dist;
		logic [ID_W-1:0]           best_id;
	} ncs_item_t;

endpackage

>>> rtl/nearest_center_search_top.sv
// ----------------------------------------------------------------------------
// nearest_center_search_top
// nearest 2d center search over a table held in a row of cells
// ----------------------------------------------------------------------------
// Every transfer on the input stream walks the row of ENTRIES cells, two
// register stages per cell, and one item is taken each cycle in which the
// output register is free or being emptied. A write lands in its slot's cell
// as it passes and gives no result; a query leaves with the id of the closest
// of the first entries_in_use slots (ties to the lowest slot) after passing
// every cell and then the output register. A stalled output stalls the whole
// row. A query must not search a slot that was never written. The user writes
// entries_in_use only while the block is idle; the block does not enforce it.
module nearest_center_search_top import ncs_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [COUNT_W-1:0]     cfg_wdata,   // entries_in_use
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,     // slot, entry_id, point_x, point_y
	input  logic                   s_tuser,     // command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,     // closest_id
	output logic                   m_tuser      // found
);

	logic [COUNT_W-1:0] count_q;
	logic               advance;

	logic               valid_chain [0:ENTRIES];
	ncs_item_t          item_chain  [0:ENTRIES];

	logic               out_valid_q;
	logic               out_found_q;
	logic [ID_W-1:0]    out_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;

	always_comb begin
		valid_chain[0]          = s_tvalid;
		item_chain[0].cmd       = cmd_t'(s_tuser);
		item_chain[0].slot      = s_tdata[SLOT_W-1:0];
		item_chain[0].entry_id  = s_tdata[SLOT_W +: ID_W];
		item_chain[0].px        = s_tdata[SLOT_W+ID_W +: COORD_W];
		item_chain[0].py        = s_tdata[SLOT_W+ID_W+COORD_W +: COORD_W];
		item_chain[0].have      = 1'b0;
		item_chain[0].best_dist = '0;
		item_chain[0].best_id   = '0;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ncs_cell #(
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.count     (count_q),
			.in_valid  (valid_chain[i]),
			.in_item   (item_chain[i]),
			.out_valid (valid_chain[i+1]),
			.out_item  (item_chain[i+1])
		);
	end

	// only queries leave the row as results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_chain[ENTRIES] && (item_chain[ENTRIES].cmd == CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_found_q <= item_chain[ENTRIES].have;
			out_id_q    <= item_chain[ENTRIES].have ? item_chain[ENTRIES].best_id : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_id_q;
	assign m_tuser  = out_found_q;

endmodule

>>> rtl/ncs_cell.sv
// ----------------------------------------------------------------------------
// ncs_cell
// one table slot: holds a center and its id, takes writes addressed to it and
// folds its squared distance into the running best of each passing query
// ----------------------------------------------------------------------------
module ncs_cell import ncs_pkg::*; #(
	parameter int unsigned INDEX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [COUNT_W-1:0] count,
	input  logic               in_valid,
	input  ncs_item_t          in_item,
	output logic               out_valid,
	output ncs_item_t          out_item
);

	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [ID_W-1:0]           id_q;

	logic                      slot_hit;
	logic signed [DIFF_W-1:0]  dx;
	logic signed [DIFF_W-1:0]  dy;
	logic signed [PROD_W-1:0]  dx2;
	logic signed [PROD_W-1:0]  dy2;

	logic                      valid_s1;
	ncs_item_t                 item_s1;
	logic [SQ_W-1:0]           sqx_s1;
	logic [SQ_W-1:0]           sqy_s1;
	logic [ID_W-1:0]           cid_s1;

	logic [DIST_W-1:0]         dist_sum;
	logic                      active;
	logic                      take;
	ncs_item_t                 item_d;

	logic                      valid_s2;
	ncs_item_t                 item_s2;

	assign slot_hit = in_valid && (in_item.cmd == CMD_WRITE) && (32'(in_item.slot) == INDEX);

	always_ff @(posedge clk) begin
		if (advance && slot_hit) begin
			cx_q <= in_item.px;
			cy_q <= in_item.py;
			id_q <= in_item.entry_id;
		end
	end

	always_comb begin
		dx  = DIFF_W'(in_item.px) - DIFF_W'(cx_q);
		dy  = DIFF_W'(in_item.py) - DIFF_W'(cy_q);
		dx2 = dx * dx;
		dy2 = dy * dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// id is captured with the squares so a write right behind cannot swap it
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= in_item;
			sqx_s1  <= dx2[SQ_W-1:0];
			sqy_s1  <= dy2[SQ_W-1:0];
			cid_s1  <= id_q;
		end
	end

	always_comb begin
		dist_sum = DIST_W'(sqx_s1) + DIST_W'(sqy_s1);
		active   = 32'(count) > INDEX;
		take     = (item_s1.cmd == CMD_QUERY) && active
			&& (!item_s1.have || (dist_sum < item_s1.best_dist));
		item_d   = item_s1;
		if (take) begin
			item_d.have      = 1'b1;
			item_d.best_dist = dist_sum;
			item_d.best_id   = cid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= item_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

>>> rtl/ncs_checker.sv
// ----------------------------------------------------------------------------
// ncs_checker
// port level checks of the nearest center search block
// ----------------------------------------------------------------------------
module ncs_checker import ncs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [COUNT_W-1:0]     cfg_wdata,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an empty search reports id zero
	a_empty_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("nonzero id without a found entry");

	// the row moves whenever the output register is free or being emptied
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output state");

	// offered items and results carry no unknown bits
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tvalid || !$isunknown({s_tuser, s_tdata}))
		&& (!m_tvalid || !$isunknown({m_tuser, m_tdata})))
		else $error("unknown bits on a valid stream");

	// the entry count changes only while no result is waiting
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !m_tvalid && !$isunknown(cfg_wdata))
		else $error("entry count written while busy");

endmodule

bind nearest_center_search_top ncs_checker u_ncs_checker (.*);

>>> tb/nearest_center_search_checker.sv
// ----------------------------------------------------------------------------
// nearest_center_search_checker
// predicts and checks every answer of the nearest center search block
// ----------------------------------------------------------------------------
// Watches the configuration port and both streams. Table writes and the entry
// count are mirrored on their transfers, and each query transfer queues the
// id of its nearest center. Every output transfer is compared with the oldest
// queued answer.
module nearest_center_search_checker import ncs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [COUNT_W-1:0]     cfg_wdata,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tuser,
	output int                     mismatches,
	output int                     outstanding,
	output int                     results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic            found;
		logic [ID_W-1:0] id;
	} answer_t;

	answer_t                   expected_answers[$];
	logic signed [COORD_W-1:0] tbl_x [ENTRIES_DEFAULT];
	logic signed [COORD_W-1:0] tbl_y [ENTRIES_DEFAULT];
	logic [ID_W-1:0]           center_id [ENTRIES_DEFAULT];
	logic [COUNT_W-1:0]        entries_in_use;

	// squared distances stay below 2^23, so plain ints hold them exactly
	function automatic answer_t nearest_center(input logic signed [COORD_W-1:0] qx,
			input logic signed [COORD_W-1:0] qy);
		answer_t best;
		int      searched;
		int      dx;
		int      dy;
		int      dist_sum;
		int      best_dist;
		best.found = 1'b0;
		best.id = '0;
		best_dist = 0;
		searched = (entries_in_use > ENTRIES_DEFAULT) ? ENTRIES_DEFAULT : entries_in_use;
		for (int i = 0; i < searched; i++) begin
			dx = int'(qx) - int'(tbl_x[i]);
			dy = int'(qy) - int'(tbl_y[i]);
			dist_sum = dx * dx + dy * dy;
			// strictly smaller only, so ties stay with the lowest slot
			if (!best.found || dist_sum < best_dist) begin
				best.found = 1'b1;
				best_dist = dist_sum;
				best.id = center_id[i];
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		answer_t                   want;
		logic [SLOT_W-1:0]         slot;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		if (!arst_n) begin
			entries_in_use = '0;
			mismatches <= 0;
			outstanding <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we)
				entries_in_use = cfg_wdata;
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_answers.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%t unexpected result: found=%0d id=%h", $time, m_tuser,
							m_tdata);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_answers.pop_front();
					if (m_tuser !== want.found || m_tdata !== want.id) begin
						if (mismatches < REPORT_LIMIT)
							$display("%t mismatch: expected found=%0d id=%h, got %0d %h",
								$time, want.found, want.id, m_tuser, m_tdata);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				slot = s_tdata[SLOT_W-1:0];
				px = s_tdata[SLOT_W+ID_W +: COORD_W];
				py = s_tdata[SLOT_W+ID_W+COORD_W +: COORD_W];
				if (cmd_t'(s_tuser) == CMD_WRITE) begin
					if (int'(slot) < ENTRIES_DEFAULT) begin
						tbl_x[slot] = px;
						tbl_y[slot] = py;
						center_id[slot] = s_tdata[SLOT_W +: ID_W];
					end
				end else begin
					expected_answers.push_back(nearest_center(px, py));
				end
			end
			outstanding <= expected_answers.size();
		end
	end

endmodule

>>> tb/tb_nearest_center_search_top.sv
// ----------------------------------------------------------------------------
// tb_nearest_center_search_top
// stimulus and verdict for the nearest center search block
// ----------------------------------------------------------------------------
// Fills the center table, runs directed queries on an empty table, on ties,
// on the coordinate extremes and on a saturated entry count, then random
// phases of table writes and queries under several entry counts and idle
// patterns. Checking is done by the checker instance beside the block.
module tb_nearest_center_search_top import ncs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_LATENCY  = 2 * ENTRIES_DEFAULT + 1;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int WRITE_PCT    = 30;
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [COUNT_W-1:0]     cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	int mismatches;
	int outstanding;
	int results_seen;
	int src_gap_pct     = 0;
	int sink_stall_pct  = 0;
	int items_sent      = 0;
	int queries_sent    = 0;
	int settings_loaded = 0;
	int quiet_cycles    = 0;
	int phase_counts [PHASES];

	nearest_center_search_top #(
		.ENTRIES(ENTRIES_DEFAULT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	nearest_center_search_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%t no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic logic [IN_TDATA_W-1:0] pack_item(input logic [SLOT_W-1:0] slot,
			input logic [ID_W-1:0] id, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		return IN_TDATA_W'({y, x, id, slot});
	endfunction

	// mostly full range, some near the origin so that ties turn up
	function automatic logic [COORD_W-1:0] random_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		if (r < 3)
			return COORD_W'(int'($urandom_range(0, 16)) - 8);
		return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
	endfunction

	task automatic send_item(input cmd_t cmd, input logic [IN_TDATA_W-1:0] data);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (cmd == CMD_QUERY)
			queries_sent++;
	endtask

	task automatic query_at(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		send_item(CMD_QUERY, pack_item(SLOT_W'($urandom), ID_W'($urandom), x, y));
	endtask

	// hold the input until every answer is out, then let the row empty
	task automatic drain_row();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (ROW_LATENCY + 8) @(posedge clk);
	endtask

	task automatic load_entries_in_use(input logic [COUNT_W-1:0] value);
		drain_row();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	task automatic random_item();
		cmd_t cmd;
		cmd = ($urandom_range(0, 99) < WRITE_PCT) ? CMD_WRITE : CMD_QUERY;
		send_item(cmd, pack_item(SLOT_W'($urandom), ID_W'($urandom), random_coord(),
			random_coord()));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		load_entries_in_use('0);
		query_at(COORD_MIN, COORD_MIN);
		query_at(COORD_MAX, COORD_MAX);

		// whole table written before any query searches it
		send_item(CMD_WRITE, pack_item(0, 16'h0000, COORD_MIN, COORD_MIN));
		send_item(CMD_WRITE, pack_item(1, 16'hFFFF, COORD_MAX, COORD_MAX));
		send_item(CMD_WRITE, pack_item(2, 16'h0002, 100, 0));
		send_item(CMD_WRITE, pack_item(3, 16'h0003, -100, 0));
		for (int k = 4; k < ENTRIES_DEFAULT; k++)
			send_item(CMD_WRITE, pack_item(SLOT_W'(k), ID_W'(16'h1000 + k),
				COORD_W'((k - 4) * 150 - 900), COORD_W'(k[0] ? 700 : -700)));

		load_entries_in_use(COUNT_W'(ENTRIES_DEFAULT));
		query_at(0, 0);
		query_at(COORD_MIN, COORD_MIN);
		query_at(COORD_MAX, COORD_MAX);
		query_at(COORD_MAX, COORD_MIN);
		query_at(COORD_MIN, COORD_MAX);

		// count above the table size searches the whole table
		load_entries_in_use('1);
		query_at(0, 0);
		load_entries_in_use(1);
		query_at(COORD_MAX, COORD_MAX);

		phase_counts = '{16, 31, 1, 0, 0, 17, 0, 16};
		phase_counts[4] = $urandom_range(2, 15);
		phase_counts[6] = $urandom_range(2, 15);
		for (int p = 0; p < PHASES; p++) begin
			load_entries_in_use(COUNT_W'(phase_counts[p]));
			case (p % 4)
				0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_gap_pct = 47; sink_stall_pct = 0;  end
				2: begin src_gap_pct = 0;  sink_stall_pct = 47; end
				default: begin src_gap_pct = 27; sink_stall_pct = 27; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2 && (p == 2 || p == 5)) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (outstanding != 0);
				end
				random_item();
			end
		end

		drain_row();
		$display("%0d items sent, %0d of them queries; %0d answers checked", items_sent,
			queries_sent, results_seen);
		$display("%0d entry-count settings, idle patterns on sender, receiver and both",
			settings_loaded);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
